// ===== src/image_border_padding_macros.svh =====
// ----------------------------------------------------------------------------
// Image border padding - assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BORDER_PADDING_MACROS_SVH
`define IMAGE_BORDER_PADDING_MACROS_SVH

// condition must hold in the cycle after any cycle with reset asserted
`define IBP_ASSERT_AFTER_RST(label, cond) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) \
    else $error("post-reset check failed");

// condition must hold in the cycle after a waiting result was not popped
`define IBP_ASSERT_STALL(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (!empty && !pop) |=> (cond)) else $error("stalled result check failed");

`endif

// ===== src/ibp_pkg.sv =====
// ----------------------------------------------------------------------------
// ibp_pkg
// Types and constants shared by the border padding engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ibp_pkg;

  // field widths
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 32;
  localparam int SIZE_W     = 9;
  localparam int PAD_W      = 8;
  localparam int MODE_W     = 2;
  localparam int POS_W      = 12;  // signed source position, -255..1023
  localparam int SPAN_W     = 11;  // padded extent, up to 766
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int KIND_W     = 2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAD_TOP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAD_BOTTOM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAD_LEFT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PAD_RIGHT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_MODE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FILL_VALUE  = 3'd7;

  // border modes
  localparam logic [MODE_W-1:0] MODE_CONSTANT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLICATE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REFLECT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REFLECT_101 = 2'd3;

  // input operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // command kinds after classification
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;  // store a source pixel
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;  // map back into the source
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;  // constant fill
  localparam logic [KIND_W-1:0] KIND_OOR   = 2'd3;  // outside padded image

  // effective (clamped) configuration
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PAD_W-1:0]  pad_top;
    logic [PAD_W-1:0]  pad_bottom;
    logic [PAD_W-1:0]  pad_left;
    logic [PAD_W-1:0]  pad_right;
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0]  fill;
  } cfg_t;

  // one queued command
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PIX_W-1:0]        pixel;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/image_border_padding.sv =====
// ----------------------------------------------------------------------------
// image_border_padding
// Border extension engine: stores source pixels and returns padded pixels
// using constant, replicate, reflect or reflect-101 border modes.
// ----------------------------------------------------------------------------
//  channel  handshake        payload
//  input    push / full      in_operation, in_coord_x, in_coord_y, in_pixel_in
//  result   empty / pop      out_pixel_out, out_out_of_range
//  config   cfg_we           cfg_index, cfg_wdata
//
//  Writes retire as the back end pops them. Fill and out-of-range reads go to
//  the response state; reads that clamp or lie in the source read the frame
//  store first, and reads that reflection folds first pass the remainder unit
//  (2 bits per cycle), wrap and mirror. A 4-word queue parts front and back;
//  a result register holds the oldest result while work continues. Synchronous
//  reset clears control only; the frame store is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module image_border_padding import ibp_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_PAD    = 255,
  parameter int CHANNELS   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  push,
  output logic                  full,
  input  logic                  in_operation,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  input  logic [PIX_W-1:0]      in_pixel_in,
  // result words
  output logic                  empty,
  input  logic                  pop,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_out_of_range,
  // configuration
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [SIZE_W-1:0] src_width_r, src_height_r;
  logic [PAD_W-1:0]  pad_top_r, pad_bottom_r, pad_left_r, pad_right_r;
  logic [MODE_W-1:0] border_mode_r;
  logic [PIX_W-1:0]  fill_value_r;

  cfg_t   cfg;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= SIZE_W'(1);
      src_height_r  <= SIZE_W'(1);
      pad_top_r     <= '0;
      pad_bottom_r  <= '0;
      pad_left_r    <= '0;
      pad_right_r   <= '0;
      border_mode_r <= MODE_CONSTANT;
      fill_value_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:   src_width_r   <= cfg_wdata[SIZE_W-1:0];
        REG_SRC_HEIGHT:  src_height_r  <= cfg_wdata[SIZE_W-1:0];
        REG_PAD_TOP:     pad_top_r     <= cfg_wdata[PAD_W-1:0];
        REG_PAD_BOTTOM:  pad_bottom_r  <= cfg_wdata[PAD_W-1:0];
        REG_PAD_LEFT:    pad_left_r    <= cfg_wdata[PAD_W-1:0];
        REG_PAD_RIGHT:   pad_right_r   <= cfg_wdata[PAD_W-1:0];
        REG_BORDER_MODE: border_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_FILL_VALUE:  fill_value_r  <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, limits saturate
  always_comb begin
    cfg.width = src_width_r;
    if (src_width_r == '0) begin
      cfg.width = SIZE_W'(1);
    end else if (int'(src_width_r) > MAX_WIDTH) begin
      cfg.width = SIZE_W'(MAX_WIDTH);
    end
    cfg.height = src_height_r;
    if (src_height_r == '0) begin
      cfg.height = SIZE_W'(1);
    end else if (int'(src_height_r) > MAX_HEIGHT) begin
      cfg.height = SIZE_W'(MAX_HEIGHT);
    end
    cfg.pad_top    = (int'(pad_top_r) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_top_r;
    cfg.pad_bottom = (int'(pad_bottom_r) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_bottom_r;
    cfg.pad_left   = (int'(pad_left_r) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_left_r;
    cfg.pad_right  = (int'(pad_right_r) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_right_r;
    cfg.mode       = border_mode_r;
    cfg.fill       = fill_value_r;
  end

  assign full = q_full;

  ibp_front u_front (
    .push         (push),
    .q_full       (q_full),
    .cfg          (cfg),
    .in_operation (in_operation),
    .in_coord_x   (in_coord_x),
    .in_coord_y   (in_coord_y),
    .in_pixel_in  (in_pixel_in),
    .q_push       (q_push),
    .q_word       (q_in)
  );

  ibp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_word (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_word (q_out),
    .empty   (q_empty)
  );

  ibp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_word           (q_out),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_pixel_out    (out_pixel_out),
    .out_out_of_range (out_out_of_range)
  );

endmodule

`default_nettype wire

// ===== src/ibp_queue.sv =====
// ----------------------------------------------------------------------------
// ibp_queue
// Small command queue that decouples the front classifier from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_queue import ibp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_word,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_word,
  output logic   empty
);

  entry_t               entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      count_r, count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_word = entries_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

`default_nettype wire

// ===== src/ibp_front.sv =====
// ----------------------------------------------------------------------------
// ibp_front
// Accepts input words, checks ranges and classifies each into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_front import ibp_pkg::*; (
  input  logic             push,
  input  logic             q_full,
  input  cfg_t             cfg,
  input  logic             in_operation,
  input  logic [COORD_W-1:0] in_coord_x,
  input  logic [COORD_W-1:0] in_coord_y,
  input  logic [PIX_W-1:0] in_pixel_in,
  output logic             q_push,
  output entry_t           q_word
);

  logic [SPAN_W-1:0]       span_x, span_y;
  logic signed [POS_W-1:0] sx, sy;
  logic                    rd_oor, in_src, wr_ok;

  // padded image extent
  assign span_x = SPAN_W'(cfg.width) + SPAN_W'(cfg.pad_left) + SPAN_W'(cfg.pad_right);
  assign span_y = SPAN_W'(cfg.height) + SPAN_W'(cfg.pad_top) + SPAN_W'(cfg.pad_bottom);
  assign rd_oor = (SPAN_W'(in_coord_x) >= span_x) || (SPAN_W'(in_coord_y) >= span_y);

  // position relative to the source origin
  assign sx = $signed(POS_W'(in_coord_x)) - $signed(POS_W'(cfg.pad_left));
  assign sy = $signed(POS_W'(in_coord_y)) - $signed(POS_W'(cfg.pad_top));
  assign in_src = (sx >= 0) && (sx < $signed(POS_W'(cfg.width))) &&
                  (sy >= 0) && (sy < $signed(POS_W'(cfg.height)));

  // writes outside the source are dropped here
  assign wr_ok = (in_coord_x < COORD_W'(cfg.width)) && (in_coord_y < COORD_W'(cfg.height));

  assign q_push = push && !q_full && ((in_operation == OP_READ) || wr_ok);

  // build the command word
  always_comb begin
    q_word.pixel = in_pixel_in;
    if (in_operation == OP_WRITE) begin
      q_word.kind  = KIND_WRITE;
      q_word.pos_x = $signed(POS_W'(in_coord_x));
      q_word.pos_y = $signed(POS_W'(in_coord_y));
    end else begin
      q_word.pos_x = sx;
      q_word.pos_y = sy;
      if (rd_oor) begin
        q_word.kind = KIND_OOR;
      end else if ((cfg.mode == MODE_CONSTANT) && !in_src) begin
        q_word.kind = KIND_FILL;
      end else begin
        q_word.kind = KIND_MAP;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ibp_back.sv =====
// ----------------------------------------------------------------------------
// ibp_back
// Executes commands: frame store writes, coordinate folding, pixel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ibp_back import ibp_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  entry_t           q_word,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [PIX_W-1:0] out_pixel_out,
  output logic             out_out_of_range
);

  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DV_W       = 2 * COORD_W;
  localparam int DIV_CYCLES = COORD_W / 2;  // two remainder bits per cycle
  localparam int STEP_W     = $clog2(DIV_CYCLES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_NEG  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] r;
    logic               neg;
    logic [COORD_W-1:0] per;
    logic               fold;  // outside the source, needs the remainder unit
  } axis_t;

  function automatic logic [PIX_W-1:0] chan_mask();
    logic [PIX_W-1:0] m;
    m = '0;
    for (int i = 0; i < PIX_W / 8; i++) begin
      if (i < CHANNELS) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [PIX_W-1:0] CH_MASK = chan_mask();

  // one restoring remainder step
  function automatic logic [COORD_W-1:0] rem_sub(input logic [COORD_W-1:0] r,
                                                 input logic [DV_W-1:0] d);
    logic [DV_W-1:0] rw;
    rw = DV_W'(r);
    if (rw >= d) rw = rw - d;
    return rw[COORD_W-1:0];
  endfunction

  // per-axis setup: clamp directly, or load the fold operands
  function automatic axis_t axis_setup(input logic signed [POS_W-1:0] p,
                                       input logic [SIZE_W-1:0] len,
                                       input logic [MODE_W-1:0] mode);
    axis_t a;
    logic  refl;
    refl   = (mode == MODE_REFLECT) || (mode == MODE_REFLECT_101);
    a.per  = (mode == MODE_REFLECT_101) ? ({1'b0, len} << 1) - COORD_W'(2)
                                        : ({1'b0, len} << 1);
    a.neg  = 1'b0;
    a.fold = 1'b0;
    a.r    = '0;
    if (len <= SIZE_W'(1)) begin
      a.r = '0;
    end else if (refl) begin
      if (p < 0) begin
        a.r    = COORD_W'(-p);
        a.neg  = 1'b1;
        a.fold = 1'b1;
      end else begin
        a.r    = COORD_W'(p);
        a.fold = (p >= $signed(POS_W'(len)));
      end
    end else if (p < 0) begin
      a.r = '0;
    end else if (p >= $signed(POS_W'(len))) begin
      a.r = COORD_W'(len) - COORD_W'(1);
    end else begin
      a.r = COORD_W'(p);
    end
    return a;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [COORD_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic                negx_r, negx_nxt, negy_r, negy_nxt;
  logic [COORD_W-1:0]  perx_r, perx_nxt, pery_r, pery_nxt;
  logic [DV_W-1:0]     dvx_r, dvx_nxt, dvy_r, dvy_nxt;
  logic [PIX_W-1:0]    direct_r, direct_nxt;
  logic                from_mem_r, from_mem_nxt;
  logic                oor_r, oor_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    out_pixel_r, out_pixel_nxt;
  logic                out_oor_r, out_oor_nxt;

  logic [PIX_W-1:0]    frame_r [DEPTH];
  logic [PIX_W-1:0]    mem_q_r;
  logic [AW-1:0]       mem_addr;
  logic                mem_we, mem_re, out_load;
  axis_t               ax, ay;

  assign q_pop            = (state_r == S_IDLE) && !q_empty;
  assign mem_we           = q_pop && (q_word.kind == KIND_WRITE);
  assign mem_re           = (state_r == S_READ);
  assign out_load         = (state_r == S_RESP) && (!out_valid_r || pop);
  assign empty            = !out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_out_of_range = out_oor_r;

  assign ax = axis_setup(q_word.pos_x, cfg.width, cfg.mode);
  assign ay = axis_setup(q_word.pos_y, cfg.height, cfg.mode);

  // store address: folded coordinate on reads, command coordinate on writes
  always_comb begin
    if (state_r == S_READ) begin
      mem_addr = AW'(int'(ry_r) * MAX_WIDTH + int'(rx_r));
    end else begin
      mem_addr = AW'(int'(q_word.pos_y[COORD_W-1:0]) * MAX_WIDTH +
                     int'(q_word.pos_x[COORD_W-1:0]));
    end
  end

  // frame store, undefined until written
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_r[mem_addr] <= q_word.pixel;
    end
    if (mem_re) begin
      mem_q_r <= frame_r[mem_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    perx_nxt      = perx_r;
    pery_nxt      = pery_r;
    dvx_nxt       = dvx_r;
    dvy_nxt       = dvy_r;
    direct_nxt    = direct_r;
    from_mem_nxt  = from_mem_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_oor_nxt   = out_oor_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_word.kind)
            KIND_FILL: begin
              direct_nxt   = cfg.fill & CH_MASK;
              from_mem_nxt = 1'b0;
              oor_nxt      = 1'b0;
              state_nxt    = S_RESP;
            end
            KIND_OOR: begin
              direct_nxt   = '0;
              from_mem_nxt = 1'b0;
              oor_nxt      = 1'b1;
              state_nxt    = S_RESP;
            end
            KIND_MAP: begin
              rx_nxt       = ax.r;
              ry_nxt       = ay.r;
              negx_nxt     = ax.neg;
              negy_nxt     = ay.neg;
              perx_nxt     = ax.per;
              pery_nxt     = ay.per;
              dvx_nxt      = DV_W'(ax.per) << (COORD_W - 1);
              dvy_nxt      = DV_W'(ay.per) << (COORD_W - 1);
              step_nxt     = '0;
              from_mem_nxt = 1'b1;
              oor_nxt      = 1'b0;
              state_nxt    = (ax.fold || ay.fold) ? S_DIV : S_READ;
            end
            default: begin
              state_nxt = S_IDLE;  // write done this cycle
            end
          endcase
        end
      end
      S_DIV: begin
        rx_nxt   = rem_sub(rem_sub(rx_r, dvx_r), dvx_r >> 1);
        ry_nxt   = rem_sub(rem_sub(ry_r, dvy_r), dvy_r >> 1);
        dvx_nxt  = dvx_r >> 2;
        dvy_nxt  = dvy_r >> 2;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_CYCLES - 1)) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: begin
        // wrap a negative remainder into the period
        if (negx_r && (rx_r != '0)) rx_nxt = perx_r - rx_r;
        if (negy_r && (ry_r != '0)) ry_nxt = pery_r - ry_r;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        // mirror the back half of the period
        if (rx_r >= COORD_W'(cfg.width)) begin
          rx_nxt = perx_r - rx_r - COORD_W'(cfg.mode == MODE_REFLECT);
        end
        if (ry_r >= COORD_W'(cfg.height)) begin
          ry_nxt = pery_r - ry_r - COORD_W'(cfg.mode == MODE_REFLECT);
        end
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = from_mem_r ? (mem_q_r & CH_MASK) : direct_r;
      out_oor_nxt   = oor_r;
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    negx_r      <= negx_nxt;
    negy_r      <= negy_nxt;
    perx_r      <= perx_nxt;
    pery_r      <= pery_nxt;
    dvx_r       <= dvx_nxt;
    dvy_r       <= dvy_nxt;
    direct_r    <= direct_nxt;
    from_mem_r  <= from_mem_nxt;
    oor_r       <= oor_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_oor_r   <= out_oor_nxt;
  end

endmodule

`default_nettype wire

// ===== src/ibp_checker.sv =====
// ----------------------------------------------------------------------------
// ibp_checker
// Port-level checks for the border padding engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_border_padding_macros.svh"

module ibp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_pixel_out
);

  // reset leaves no stale result and an open input
  `IBP_ASSERT_AFTER_RST(a_rst_empty, empty)
  `IBP_ASSERT_AFTER_RST(a_rst_not_full, !full)

  // a waiting result is neither lost nor altered while stalled
  `IBP_ASSERT_STALL(a_hold_valid, !empty)
  `IBP_ASSERT_STALL(a_hold_pixel, $stable(out_pixel_out))

endmodule

bind image_border_padding ibp_checker u_ibp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_pixel_out (out_pixel_out)
);

`default_nettype wire
